// File: sv/aot_pkg.sv
`timescale 1ns / 1ps

package aot_pkg;

  localparam int unsigned ENTRIES    = 64;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned KEY_W      = 48;
  localparam int unsigned IPV4_W     = 32;
  localparam int unsigned TABLES     = 4;
  localparam int unsigned SEL_W      = 2;
  localparam int unsigned IDX_W      = $clog2(ENTRIES);
  localparam int unsigned FILL_W     = $clog2(ENTRIES + 1);
  localparam int unsigned OUT_IDX_W  = 6;
  localparam int unsigned OUT_CNT_W  = 32;

  typedef enum logic [SEL_W-1:0] {
    TBL_SRC_MAC,
    TBL_DST_MAC,
    TBL_SRC_IPV4,
    TBL_DST_IPV4
  } tbl_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_HOLD
  } state_e;

  // Lookup token walking down the cell chain
  typedef struct packed {
    logic                  active;
    tbl_e                  sel;
    logic [KEY_W-1:0]      key;
    logic [FILL_W-1:0]     fill;
    logic                  hit;
    logic [IDX_W-1:0]      pos;
    logic [COUNT_BITS-1:0] count;
  } token_t;

  typedef struct packed {
    logic                 matched;
    logic [OUT_IDX_W-1:0] index;
    logic [OUT_CNT_W-1:0] count;
    logic                 full;
  } result_t;

  function automatic logic [OUT_IDX_W-1:0] out_index(logic [IDX_W-1:0] pos);
    logic [63:0] w;
    w = 64'(pos);
    return w[OUT_IDX_W-1:0];
  endfunction

  function automatic logic [OUT_CNT_W-1:0] out_count(logic [COUNT_BITS-1:0] cnt);
    logic [63:0] w;
    w = 64'(cnt);
    return w[OUT_CNT_W-1:0];
  endfunction

endpackage

// File: sv/aot_cell.sv
`timescale 1ns / 1ps

module aot_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [aot_pkg::IDX_W-1:0]  cell_idx_i,
  input  aot_pkg::token_t            tok_i,
  output aot_pkg::token_t            tok_o
);

  logic [aot_pkg::KEY_W-1:0]      key_q [aot_pkg::TABLES];
  logic [aot_pkg::COUNT_BITS-1:0] cnt_q [aot_pkg::TABLES];

  aot_pkg::token_t                tok_q;
  aot_pkg::token_t                tok_d;
  logic                           live;
  logic                           match;
  logic                           append;
  logic [aot_pkg::FILL_W-1:0]     idx_ext;
  logic [aot_pkg::COUNT_BITS-1:0] cnt_cur;
  logic [aot_pkg::COUNT_BITS-1:0] cnt_inc;

  always_comb begin
    idx_ext = aot_pkg::FILL_W'(cell_idx_i);
    live    = tok_i.active && !tok_i.hit;
    match   = live && (idx_ext < tok_i.fill) && (key_q[tok_i.sel] == tok_i.key);
    append  = live && (idx_ext == tok_i.fill);
    cnt_cur = cnt_q[tok_i.sel];
    // saturate at all ones
    cnt_inc = (&cnt_cur) ? cnt_cur : cnt_cur + 1'b1;
    tok_d   = tok_i;
    if (match) begin
      tok_d.hit   = 1'b1;
      tok_d.pos   = cell_idx_i;
      tok_d.count = cnt_inc;
    end else if (append) begin
      tok_d.pos   = cell_idx_i;
      tok_d.count = aot_pkg::COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (match) begin
      cnt_q[tok_i.sel] <= cnt_inc;
    end else if (append) begin
      key_q[tok_i.sel] <= tok_i.key;
      cnt_q[tok_i.sel] <= aot_pkg::COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

`ifndef ASSERT_OFF
  a_match_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match |=> (tok_q.hit && tok_q.count != '0))
    else $error("hit left the cell with a zero count");

  a_append_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    append |=> (!tok_q.hit && tok_q.count == aot_pkg::COUNT_BITS'(1)))
    else $error("appended entry did not report a count of one");
`endif

endmodule

// File: sv/aot_ctrl.sv
`timescale 1ns / 1ps

module aot_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [aot_pkg::SEL_W-1:0]     table_select_i,
  input  logic [aot_pkg::KEY_W-1:0]     key_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          matched_o,
  output logic [aot_pkg::OUT_IDX_W-1:0] entry_index_o,
  output logic [aot_pkg::OUT_CNT_W-1:0] occurrence_count_o,
  output logic                          table_full_o,
  output aot_pkg::token_t               inj_o,
  input  aot_pkg::token_t               done_i
);

  aot_pkg::state_e            state_q;
  aot_pkg::state_e            state_d;
  logic [aot_pkg::FILL_W-1:0] fill_q [aot_pkg::TABLES];
  aot_pkg::token_t            inj_q;
  aot_pkg::token_t            inj_d;
  logic                       out_valid_q;
  logic                       out_valid_d;
  aot_pkg::result_t           out_res_q;
  aot_pkg::result_t           out_res_d;
  aot_pkg::result_t           pend_q;
  aot_pkg::result_t           pend_d;
  aot_pkg::result_t           res_now;
  aot_pkg::tbl_e              sel_in;
  logic                       in_acc;
  logic                       out_acc;
  logic                       finish;
  logic                       appended;
  logic                       is_ipv4;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aot_pkg::ST_IDLE: begin
        if (in_acc) state_d = aot_pkg::ST_BUSY;
      end
      aot_pkg::ST_BUSY: begin
        if (done_i.active) begin
          state_d = (!out_valid_q || out_ready_i) ? aot_pkg::ST_IDLE : aot_pkg::ST_HOLD;
        end
      end
      aot_pkg::ST_HOLD: begin
        if (out_ready_i) state_d = aot_pkg::ST_IDLE;
      end
      default: state_d = aot_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_ready_o = (state_q == aot_pkg::ST_IDLE);
    in_acc     = in_valid_i && in_ready_o;
    out_acc    = out_valid_q && out_ready_i;
    sel_in     = aot_pkg::tbl_e'(table_select_i);
    is_ipv4    = (sel_in == aot_pkg::TBL_SRC_IPV4) || (sel_in == aot_pkg::TBL_DST_IPV4);
    finish     = (state_q == aot_pkg::ST_BUSY) && done_i.active;
    appended   = !done_i.hit && (done_i.fill != aot_pkg::FILL_W'(aot_pkg::ENTRIES));

    inj_d = '0;
    if (in_acc) begin
      inj_d.active = 1'b1;
      inj_d.sel    = sel_in;
      inj_d.key    = is_ipv4
                     ? aot_pkg::KEY_W'(key_value_i[aot_pkg::IPV4_W-1:0])
                     : key_value_i;
      inj_d.fill   = fill_q[sel_in];
    end

    res_now.matched = done_i.hit;
    res_now.index   = aot_pkg::out_index(done_i.pos);
    res_now.count   = aot_pkg::out_count(done_i.count);
    res_now.full    = !done_i.hit && !appended;

    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    pend_d      = pend_q;
    if (finish) begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_d = 1'b1;
        out_res_d   = res_now;
      end else begin
        pend_d = res_now;
      end
    end else if ((state_q == aot_pkg::ST_HOLD) && out_ready_i) begin
      out_res_d = pend_q;
    end else if (out_acc) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aot_pkg::ST_IDLE;
      inj_q       <= '0;
      out_valid_q <= 1'b0;
      for (int t = 0; t < aot_pkg::TABLES; t++) begin
        fill_q[t] <= '0;
      end
    end else begin
      state_q     <= state_d;
      inj_q       <= inj_d;
      out_valid_q <= out_valid_d;
      if (finish && appended) begin
        fill_q[done_i.sel] <= done_i.fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
    pend_q    <= pend_d;
  end

  assign inj_o              = inj_q;
  assign out_valid_o        = out_valid_q;
  assign matched_o          = out_res_q.matched;
  assign entry_index_o      = out_res_q.index;
  assign occurrence_count_o = out_res_q.count;
  assign table_full_o       = out_res_q.full;

`ifndef ASSERT_OFF
  a_idle_chain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aot_pkg::ST_IDLE) |-> !done_i.active)
    else $error("token left the chain while idle");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q[0] <= aot_pkg::FILL_W'(aot_pkg::ENTRIES)) &&
    (fill_q[1] <= aot_pkg::FILL_W'(aot_pkg::ENTRIES)) &&
    (fill_q[2] <= aot_pkg::FILL_W'(aot_pkg::ENTRIES)) &&
    (fill_q[3] <= aot_pkg::FILL_W'(aot_pkg::ENTRIES)))
    else $error("fill level beyond table size");

  a_hold_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aot_pkg::ST_HOLD) |-> out_valid_q)
    else $error("holding a result with an empty output register");

  a_accept_injects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ((state_q == aot_pkg::ST_BUSY) && inj_q.active))
    else $error("accepted word was not injected");
`endif

endmodule

// File: sv/address_occurrence_table_top.sv
`timescale 1ns / 1ps

// Channel | Handshake                  | Payload
// --------+----------------------------+------------------------------------------
// input   | in_valid_i / in_ready_o    | table_select_i[1:0], key_value_i[47:0]
// output  | out_valid_o / out_ready_i  | matched_o, entry_index_o[5:0],
//         |                            | occurrence_count_o[31:0], table_full_o
//
// A word passes through the injection register, one cell per cycle, then the
// output register. Reset clears the fill levels and control; stored keys and
// counts are only read below the fill level. A stalled output does not block
// the next word; a result that finishes meanwhile waits in a holding register
// and blocks the input until the output drains.

module address_occurrence_table_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [aot_pkg::SEL_W-1:0]     table_select_i,
  input  logic [aot_pkg::KEY_W-1:0]     key_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          matched_o,
  output logic [aot_pkg::OUT_IDX_W-1:0] entry_index_o,
  output logic [aot_pkg::OUT_CNT_W-1:0] occurrence_count_o,
  output logic                          table_full_o
);

  // chain links: link 0 is the injected token, the last link leaves the chain
  aot_pkg::token_t link [aot_pkg::ENTRIES+1];

  aot_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .table_select_i     (table_select_i),
    .key_value_i        (key_value_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .matched_o          (matched_o),
    .entry_index_o      (entry_index_o),
    .occurrence_count_o (occurrence_count_o),
    .table_full_o       (table_full_o),
    .inj_o              (link[0]),
    .done_i             (link[aot_pkg::ENTRIES])
  );

  // Cell k holds entry k of all four tables. The token compares against the
  // cell while the entry lies below the table's fill level, claims the cell
  // for a new key when the cell index equals the fill level, and otherwise
  // passes through unchanged.
  for (genvar k = 0; k < aot_pkg::ENTRIES; k++) begin : g_cell
    aot_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (aot_pkg::IDX_W'(k)),
      .tok_i      (link[k]),
      .tok_o      (link[k+1])
    );
  end

endmodule

// File: tb/tb_address_occurrence_table_top.sv
`timescale 1ns / 1ps

module tb_address_occurrence_table_top;

  // One lookup word as offered on the input channel
  typedef struct packed {
    aot_pkg::tbl_e             sel;
    logic [aot_pkg::KEY_W-1:0] key;
  } lookup_word_t;

  localparam int unsigned RANDOM_WORDS = 435;
  localparam int unsigned POOL_DEPTH   = 512;
  localparam int unsigned DRAIN_CYCLES = aot_pkg::ENTRIES + 8;

  logic clk_i  = 1'b0;
  logic rst_n  = 1'b0;

  // Input channel, driven on the falling edge
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  aot_pkg::tbl_e             sel_drv   = aot_pkg::TBL_SRC_MAC;
  logic [aot_pkg::KEY_W-1:0] key_drv   = '0;

  // Output channel
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          matched;
  logic [aot_pkg::OUT_IDX_W-1:0] entry_index;
  logic [aot_pkg::OUT_CNT_W-1:0] occ_count;
  logic                          table_full;

  // Words waiting to be offered, and results waiting to be seen
  lookup_word_t      lookup_words[$];
  aot_pkg::result_t  expected_results[$];
  lookup_word_t      next_word;
  int unsigned       total_words;

  // Handshake bookkeeping: each counter has a single writer
  int unsigned words_offered = 0;
  int unsigned words_taken   = 0;

  // Scoreboard tallies
  int unsigned failures     = 0;
  int unsigned hits_seen    = 0;
  int unsigned appends_seen = 0;
  int unsigned drops_seen   = 0;

  // Predictor state: a shadow of the four address tables
  logic [aot_pkg::KEY_W-1:0]      shadow_keys   [aot_pkg::TABLES][aot_pkg::ENTRIES];
  logic [aot_pkg::COUNT_BITS-1:0] shadow_counts [aot_pkg::TABLES][aot_pkg::ENTRIES];
  int unsigned                    shadow_fill   [aot_pkg::TABLES];

  // Generator memory of keys already offered, per table, for forcing hits
  logic [aot_pkg::KEY_W-1:0] offered_keys  [aot_pkg::TABLES][POOL_DEPTH];
  int unsigned               offered_count [aot_pkg::TABLES];

  // Sender burst shaping and receiver stall pattern
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned ready_left = 0;
  int unsigned ready_mode = 0;

  address_occurrence_table_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .table_select_i     (sel_drv),
    .key_value_i        (key_drv),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .matched_o          (matched),
    .entry_index_o      (entry_index),
    .occurrence_count_o (occ_count),
    .table_full_o       (table_full)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit is_ipv4(aot_pkg::tbl_e sel);
    return (sel == aot_pkg::TBL_SRC_IPV4) || (sel == aot_pkg::TBL_DST_IPV4);
  endfunction

  // Work out the result of one accepted word and update the shadow tables.
  // IPv4 tables see only the low 32 bits; a full table drops new keys.
  function automatic void predict_lookup(aot_pkg::tbl_e sel,
                                         logic [aot_pkg::KEY_W-1:0] raw_key);
    logic [aot_pkg::KEY_W-1:0] key;
    int unsigned               t;
    int                        pos;
    aot_pkg::result_t          res;
    key = is_ipv4(sel)
          ? {{(aot_pkg::KEY_W-aot_pkg::IPV4_W){1'b0}}, raw_key[aot_pkg::IPV4_W-1:0]}
          : raw_key;
    t   = int'(sel);
    pos = -1;
    for (int i = 0; i < int'(shadow_fill[t]); i++) begin
      if (pos < 0 && shadow_keys[t][i] == key) pos = i;
    end
    res = '0;
    if (pos >= 0) begin
      // saturate rather than wrap
      if (shadow_counts[t][pos] != '1) begin
        shadow_counts[t][pos] = shadow_counts[t][pos] + 1'b1;
      end
      res.matched = 1'b1;
      res.index   = aot_pkg::OUT_IDX_W'(pos);
      res.count   = aot_pkg::OUT_CNT_W'(shadow_counts[t][pos]);
    end else if (shadow_fill[t] < aot_pkg::ENTRIES) begin
      shadow_keys[t][shadow_fill[t]]   = key;
      shadow_counts[t][shadow_fill[t]] = aot_pkg::COUNT_BITS'(1);
      res.index = aot_pkg::OUT_IDX_W'(shadow_fill[t]);
      res.count = aot_pkg::OUT_CNT_W'(1);
      shadow_fill[t]++;
    end else begin
      res.full = 1'b1;
    end
    expected_results = {expected_results, res};
  endfunction

  // Queue one word and remember its key for later repeats
  function automatic void add_word(aot_pkg::tbl_e sel, logic [aot_pkg::KEY_W-1:0] key);
    int unsigned t;
    lookup_word_t w;
    t = int'(sel);
    w.sel = sel;
    w.key = key;
    lookup_words = {lookup_words, w};
    if (offered_count[t] < POOL_DEPTH) begin
      offered_keys[t][offered_count[t]] = key;
      offered_count[t]++;
    end
  endfunction

  // Random words: mostly fresh keys so tables fill up and overflow, the rest
  // repeats of earlier keys; IPv4 repeats get fresh upper bits.
  function automatic void add_random_words(int unsigned n);
    aot_pkg::tbl_e             sel;
    logic [aot_pkg::KEY_W-1:0] key;
    int unsigned               t;
    for (int unsigned k = 0; k < n; k++) begin
      sel = aot_pkg::tbl_e'($urandom_range(0, aot_pkg::TABLES - 1));
      t   = int'(sel);
      key = aot_pkg::KEY_W'({$urandom(), $urandom()});
      if (offered_count[t] != 0 && $urandom_range(0, 99) < 38) begin
        key = offered_keys[t][$urandom_range(0, offered_count[t] - 1)];
        if (is_ipv4(sel)) begin
          key[aot_pkg::KEY_W-1:aot_pkg::IPV4_W] =
            (aot_pkg::KEY_W-aot_pkg::IPV4_W)'($urandom());
        end
      end
      add_word(sel, key);
    end
  endfunction

  // Driver: advance to the next word only once the current one is taken
  always @(negedge clk_i) begin
    if (rst_n && (!in_valid || words_taken == words_offered)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (lookup_words.size() > 0) begin
        next_word = lookup_words.pop_front();
        in_valid  <= 1'b1;
        sel_drv   <= next_word.sel;
        key_drv   <= next_word.key;
        words_offered++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // new burst; a quarter of the time no gap at all
          burst_left = $urandom_range(0, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: alternate stretches of always-ready, hard stall and coin flips
  always @(negedge clk_i) begin
    if (rst_n) begin
      if (ready_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        ready_left = $urandom_range(1, 120);
      end
      ready_left--;
      case (ready_mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= 1'b0;
        end
        default: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
      endcase
    end
  end

  // Monitor: predict on every accepted input word, check every result word
  always @(posedge clk_i) begin
    aot_pkg::result_t exp_res;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_lookup(sel_drv, key_drv);
        words_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: matched=%0b index=%0d count=%0d full=%0b",
                 matched, entry_index, occ_count, table_full);
          failures++;
        end else begin
          exp_res = expected_results.pop_front();
          if (exp_res.full) drops_seen++;
          else if (exp_res.matched) hits_seen++;
          else appends_seen++;
          if (matched !== exp_res.matched) begin
            $error("matched: expected %0b, got %0b", exp_res.matched, matched);
            failures++;
          end
          if (entry_index !== exp_res.index) begin
            $error("entry_index: expected %0d, got %0d", exp_res.index, entry_index);
            failures++;
          end
          if (occ_count !== exp_res.count) begin
            $error("occurrence_count: expected %0d, got %0d", exp_res.count, occ_count);
            failures++;
          end
          if (table_full !== exp_res.full) begin
            $error("table_full: expected %0b, got %0b", exp_res.full, table_full);
            failures++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned tables_filled;
    for (int t = 0; t < aot_pkg::TABLES; t++) begin
      shadow_fill[t]   = 0;
      offered_count[t] = 0;
    end

    // Directed: key extremes, single-bit keys, IPv4 upper bits ignored on
    // both store and compare, and an early repeat in every table.
    add_word(aot_pkg::TBL_SRC_MAC,  48'h0000_0000_0000);
    add_word(aot_pkg::TBL_SRC_MAC,  48'hFFFF_FFFF_FFFF);
    add_word(aot_pkg::TBL_SRC_MAC,  48'h0000_0000_0000);
    add_word(aot_pkg::TBL_SRC_MAC,  48'hAAAA_AAAA_AAAA);
    add_word(aot_pkg::TBL_SRC_MAC,  48'h5555_5555_5555);
    add_word(aot_pkg::TBL_DST_MAC,  48'hFFFF_FFFF_FFFF);
    add_word(aot_pkg::TBL_DST_MAC,  48'h8000_0000_0000);
    add_word(aot_pkg::TBL_DST_MAC,  48'h0000_0000_0001);
    add_word(aot_pkg::TBL_DST_MAC,  48'h8000_0000_0000);
    add_word(aot_pkg::TBL_SRC_IPV4, 48'hFFFF_FFFF_FFFF);
    add_word(aot_pkg::TBL_SRC_IPV4, 48'h0000_FFFF_FFFF);
    add_word(aot_pkg::TBL_SRC_IPV4, 48'hFFFF_0000_0000);
    add_word(aot_pkg::TBL_SRC_IPV4, 48'h0000_0000_0000);
    add_word(aot_pkg::TBL_DST_IPV4, 48'h1234_C0A8_0001);
    add_word(aot_pkg::TBL_DST_IPV4, 48'h0000_C0A8_0001);
    add_word(aot_pkg::TBL_DST_IPV4, 48'h5555_5555_5555);
    add_word(aot_pkg::TBL_DST_IPV4, 48'hAAAA_AAAA_AAAA);
    add_word(aot_pkg::TBL_DST_IPV4, 48'hFFFF_C0A8_0001);
    add_random_words(RANDOM_WORDS);
    total_words = lookup_words.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // Hold until every word is taken and every result has come back
    while (words_taken != total_words || expected_results.size() != 0) @(posedge clk_i);
    // Drain: catch any stray result words
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    tables_filled = 0;
    for (int t = 0; t < aot_pkg::TABLES; t++) begin
      if (shadow_fill[t] == aot_pkg::ENTRIES) tables_filled++;
    end
    $display("Covered %0d lookups: %0d repeats, %0d new entries, %0d drops on a full table",
             total_words, hits_seen, appends_seen, drops_seen);
    $display("Address tables driven to capacity: %0d of %0d", tables_filled,
             aot_pkg::TABLES);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Timeout waiting for the block to drain");
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: address_occurrence_table_top.f
sv/aot_pkg.sv
sv/aot_cell.sv
sv/aot_ctrl.sv
sv/address_occurrence_table_top.sv
tb/tb_address_occurrence_table_top.sv
